// ===== src/ste_pkg.sv =====
// Shared widths, request codes and helpers for the servo target easing unit.
package ste_pkg;

	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 24;
	localparam int SPD_W     = 16;
	localparam int CFG_W     = 16;
	localparam int DVS_W     = SPD_W - 1;

	localparam logic signed [SPD_W-1:0] DEFAULT_DIVISOR = 16'sd1000;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_MOVE   = 2'd1,
		REQ_STOP   = 2'd2,
		REQ_RESUME = 2'd3
	} req_t;

	typedef enum logic {
		CFG_GRACE = 1'b0,
		CFG_TOL   = 1'b1
	} cfg_idx_t;

	// Divisor of zero or below falls back to the default step divisor.
	function automatic logic signed [SPD_W-1:0] fix_divisor(input logic signed [SPD_W-1:0] d);
		logic signed [SPD_W-1:0] r;
		r = (d <= 0) ? DEFAULT_DIVISOR : d;
		return r;
	endfunction

endpackage

// ===== src/ste_divider.sv =====
// Restoring divider, one quotient bit per cycle, unsigned dividend by positive divisor.
module ste_divider
	import ste_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [POS_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [POS_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(POS_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [POS_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W+1:0] trial;
	logic             take;
	logic [DVS_W-1:0] rem_n;

	always_comb begin
		rem_sh = {rem_q, quo_q[POS_W-1]};
		trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
		take   = !trial[DVS_W+1];
		rem_n  = take ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(POS_W);
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
			end else if (busy_q) begin
				rem_q <= rem_n;
				quo_q <= {quo_q[POS_W-2:0], take};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== src/servo_target_easing_unit.sv =====
// Top level: request decode, easing sequencer, state registers and output word register.
//
// Servo easing in unsigned Q8.16 degrees. Each input word is one request: tick,
// move, forced stop or resume, and each gives exactly one output word. Move, stop,
// resume and a paused tick go from acceptance straight to the emit step, which loads
// the output register. A tick that steps passes through the prep, divide and emit
// steps; in the divide step the restoring divider forms |target - position| / divisor
// one quotient bit per cycle. The input side is ready only while the sequencer is
// idle, and the sequencer waits in its emit step while the output register still
// holds an unaccepted word. A finished word may wait in the output register while
// the next request is already taken.
module servo_target_easing_unit
	import ste_pkg::*;
#(
	parameter int MAX_ANGLE = 180
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // target_angle[23:0], move_speed[39:24]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// servo_angle[7:0], angle_written[8], position_fixed[32:9], in_motion[33],
	// cue_pending[34], paused[35], zero[39:36]
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [POS_W-1:0] TOP_POS = POS_W'(MAX_ANGLE << FRAC_BITS);
	localparam logic [POS_W:0]   HALF    = (POS_W+1)'(1) << (FRAC_BITS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]        grace_q, tol_q, gc_q;
	logic [POS_W-1:0]        pos_q, target_q, cue_target_q;
	logic signed [SPD_W-1:0] sd_q, cue_div_q;
	logic                    cue_valid_q, moving_q, stop_q, neg_q;
	logic                    wrote_q, blocked_q;
	logic                    m_tvalid_q;
	logic [39:0]             m_tdata_q;

	logic                    accept;
	req_t                    req;
	logic [POS_W-1:0]        tgt_in, tgt_sat;
	logic signed [SPD_W-1:0] spd_in;
	logic                    grace_hold;
	logic signed [POS_W:0]   diff;
	logic [POS_W:0]          span;
	logic                    arrived_s, near, blocked, step_go;
	logic                    div_start, div_done;
	logic [POS_W-1:0]        quo;
	logic signed [SPD_W-1:0] sd_fixed, cue_fixed;
	logic [POS_W:0]          rnd;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign req      = req_t'(s_tuser);
	assign tgt_in   = s_tdata[POS_W-1:0];
	assign spd_in   = s_tdata[POS_W+SPD_W-1:POS_W];

	always_comb begin
		tgt_sat    = (tgt_in > TOP_POS) ? TOP_POS : tgt_in;
		grace_hold = gc_q < grace_q;
		// one subtractor serves the arrival tests at accept and the dividend in prep
		diff       = $signed({1'b0, target_q}) - $signed({1'b0, pos_q});
		span       = $unsigned(diff[POS_W] ? -diff : diff);
		arrived_s  = diff <= $signed({{(POS_W+1-CFG_W){1'b0}}, tol_q});
		near       = span <= {{(POS_W+1-CFG_W){1'b0}}, tol_q};
		blocked    = stop_q || grace_hold;
		step_go    = (req == REQ_TICK) && !blocked;
		sd_fixed   = fix_divisor(sd_q);
		cue_fixed  = fix_divisor(cue_div_q);
		div_start  = (state_q == ST_PREP);
		rnd        = {1'b0, pos_q} + HALF;
	end

	ste_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (span[POS_W-1:0]),
		.divisor  (sd_q[DVS_W-1:0]),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			grace_q      <= '0;
			tol_q        <= CFG_W'(655);
			gc_q         <= '0;
			pos_q        <= '0;
			target_q     <= '0;
			sd_q         <= '0;
			cue_target_q <= '0;
			cue_div_q    <= '0;
			cue_valid_q  <= 1'b0;
			moving_q     <= 1'b0;
			stop_q       <= 1'b0;
			neg_q        <= 1'b0;
			wrote_q      <= 1'b0;
			blocked_q    <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_GRACE: grace_q <= cfg_data;
					CFG_TOL:   tol_q   <= cfg_data;
					default:   ;
				endcase
			end

			// the emit step reloads the register itself when the word leaves
			if (m_tvalid_q && m_tready && state_q != ST_EMIT)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wrote_q   <= step_go;
						blocked_q <= (req == REQ_TICK) && blocked;
						state_q   <= step_go ? ST_PREP : ST_EMIT;
						unique case (req)
							REQ_MOVE: begin
								if (moving_q) begin
									if (!cue_valid_q) begin
										cue_valid_q  <= 1'b1;
										cue_target_q <= tgt_sat;
										cue_div_q    <= spd_in;
									end
								end else begin
									target_q <= tgt_sat;
									sd_q     <= spd_in;
								end
							end
							REQ_STOP:   stop_q <= 1'b1;
							REQ_RESUME: stop_q <= 1'b0;
							REQ_TICK: begin
								if (blocked) begin
									gc_q     <= grace_hold ? gc_q + 1'b1 : grace_q;
									moving_q <= arrived_s ? 1'b0 : moving_q;
									sd_q     <= sd_fixed;
								end else begin
									moving_q <= 1'b1;
									// when near the target, a queued cue goes live
									if (near) begin
										gc_q <= grace_q;
										if (cue_valid_q) begin
											target_q     <= cue_target_q;
											sd_q         <= cue_fixed;
											cue_valid_q  <= 1'b0;
											cue_target_q <= '0;
											cue_div_q    <= '0;
										end else begin
											sd_q <= sd_fixed;
										end
									end else begin
										gc_q <= '0;
										sd_q <= sd_fixed;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					neg_q   <= diff[POS_W];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						// the step lies between position and target, so no clamp is reached
						pos_q   <= neg_q ? pos_q - quo : pos_q + quo;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0000, blocked_q, cue_valid_q, moving_q, pos_q, wrote_q,
							rnd[FRAC_BITS +: 8]};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A new output word is only loaded by the emit step.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_EMIT))
		else $error("output word loaded outside emit");

	// The divider only finishes while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside divide step");

	// Steps never leave the valid angle range.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= TOP_POS && target_q <= TOP_POS)
		else $error("position or target out of range");

endmodule
